// ===== rtl/core/tcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpd_pkg
// Shared types, widths and register codes of the two-channel PID drive core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcpd_pkg;

   // fixed field widths
   localparam int TARGET_BITS   = 24;
   localparam int GAIN_BITS     = 32;
   localparam int INTEG_BITS    = 48;
   localparam int DRIVE_BITS    = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   // defaults for the top-level parameters
   localparam int POSITION_BITS_DEF  = 24;
   localparam int GAIN_FRAC_BITS_DEF = 24;
   localparam int MAX_DRIVE_DEF      = 100;

   // gain reset values, Q8.24
   localparam logic [GAIN_BITS-1:0] LEFT_KP_RST  = 32'd805306;
   localparam logic [GAIN_BITS-1:0] LEFT_KI_RST  = 32'd151;
   localparam logic [GAIN_BITS-1:0] LEFT_KD_RST  = 32'd43621;
   localparam logic [GAIN_BITS-1:0] RIGHT_KP_RST = 32'd805306;
   localparam logic [GAIN_BITS-1:0] RIGHT_KI_RST = 32'd143;
   localparam logic [GAIN_BITS-1:0] RIGHT_KD_RST = 32'd20133;

   // register map
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TARGET   = 3'd0,
      CSR_LEFT_KP  = 3'd1,
      CSR_LEFT_KI  = 3'd2,
      CSR_LEFT_KD  = 3'd3,
      CSR_RIGHT_KP = 3'd4,
      CSR_RIGHT_KI = 3'd5,
      CSR_RIGHT_KD = 3'd6
   } csr_index_type;

   // pipeline control handed from the merge stage to the lanes
   typedef struct packed {
      logic accept;
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } pipe_ctl_type;

endpackage

// ===== rtl/core/tcpd_lane.sv =====
// ----------------------------------------------------------------------------
// tcpd_lane
// One side of the controller: error, integral and last-error state, then a
// product stage, a partial-sum stage and the final sum with drive clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpd_lane
   import tcpd_pkg::*;
#(
   parameter int POSITION_BITS  = POSITION_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
   parameter int MAX_DRIVE      = MAX_DRIVE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pipe_ctl_type                    ctl,
   input  logic                            start_move,
   input  logic                            done,
   input  logic        [TARGET_BITS-1:0]   tabs,
   input  logic signed [POSITION_BITS-1:0] position,
   input  logic        [GAIN_BITS-1:0]     kp,
   input  logic        [GAIN_BITS-1:0]     ki,
   input  logic        [GAIN_BITS-1:0]     kd,
   output logic        [DRIVE_BITS-1:0]    mag
);

   localparam int EB  = ((POSITION_BITS > TARGET_BITS) ? POSITION_BITS : TARGET_BITS) + 1;
   localparam int DB  = EB + 1;
   localparam int IB  = INTEG_BITS;
   localparam int LO  = IB / 2;
   localparam int HI  = IB - LO;
   localparam int PEW = GAIN_BITS + 1 + EB;
   localparam int PDW = GAIN_BITS + 1 + DB;
   localparam int PLW = GAIN_BITS + LO;
   localparam int PHW = GAIN_BITS + 1 + HI;
   localparam int AW  = PDW + 1;
   localparam int IW  = GAIN_BITS + 1 + IB;
   localparam int SW  = ((IW > AW) ? IW : AW) + 1;
   localparam int IPW = SW - GAIN_FRAC_BITS;

   // state
   logic signed [IB-1:0]  integ_ff;
   logic signed [EB-1:0]  last_ff;

   // stage 1
   logic signed [EB-1:0]  e1_ff;
   logic signed [IB-1:0]  i1_ff;
   logic signed [DB-1:0]  d1_ff;

   // stage 2
   logic signed [PEW-1:0] pe_ff;
   logic signed [PDW-1:0] pd_ff;
   logic        [PLW-1:0] pl_ff;
   logic signed [PHW-1:0] ph_ff;

   // stage 3
   logic signed [AW-1:0]  a3_ff;
   logic signed [SW-1:0]  b3_ff;

   logic        [POSITION_BITS-1:0] pabs;
   logic signed [EB-1:0]  err;
   logic signed [IB-1:0]  integ_cur;
   logic signed [EB-1:0]  last_cur;
   logic signed [IB:0]    integ_sum;
   logic signed [IB-1:0]  integ_sat;
   logic signed [DB-1:0]  diff;
   logic signed [SW-1:0]  sum;
   logic        [IPW-1:0] ipart;

   // error and saturating integral for the item being accepted
   always_comb begin
      pabs      = position[POSITION_BITS-1] ? POSITION_BITS'(-position)
                                            : POSITION_BITS'(position);
      err       = $signed(EB'(tabs)) - $signed(EB'(pabs));
      integ_cur = start_move ? '0 : integ_ff;
      last_cur  = start_move ? '0 : last_ff;
      integ_sum = (IB+1)'(integ_cur) + (IB+1)'(err);
      if (integ_sum[IB] != integ_sum[IB-1]) begin
         integ_sat = integ_sum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
      end else begin
         integ_sat = integ_sum[IB-1:0];
      end
      diff = DB'(err) - DB'(last_cur);
   end

   // integral and last error; a done item leaves them alone unless it starts a move
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else if (ctl.accept) begin
         if (!done) begin
            integ_ff <= integ_sat;
            last_ff  <= err;
         end else if (start_move) begin
            integ_ff <= '0;
            last_ff  <= '0;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         e1_ff <= err;
         i1_ff <= integ_sat;
         d1_ff <= diff;
      end
      // integral product split into low (unsigned) and high (signed) halves
      if (ctl.s2_en) begin
         pe_ff <= PEW'($signed({1'b0, kp})) * PEW'(e1_ff);
         pd_ff <= PDW'($signed({1'b0, kd})) * PDW'(d1_ff);
         pl_ff <= PLW'(ki) * PLW'(i1_ff[LO-1:0]);
         ph_ff <= PHW'($signed({1'b0, ki})) * PHW'($signed(i1_ff[IB-1:LO]));
      end
      if (ctl.s3_en) begin
         a3_ff <= AW'(pe_ff) + AW'(pd_ff);
         b3_ff <= (SW'(ph_ff) <<< LO) + $signed(SW'(pl_ff));
      end
   end

   // final sum, truncation and clamp to 1..MAX_DRIVE
   always_comb begin
      sum   = SW'(a3_ff) + b3_ff;
      ipart = sum[SW-1:GAIN_FRAC_BITS];
      if (sum[SW-1]) begin
         mag = DRIVE_BITS'(1);
      end else if (ipart > IPW'(MAX_DRIVE)) begin
         mag = DRIVE_BITS'(MAX_DRIVE);
      end else if (ipart == '0) begin
         mag = DRIVE_BITS'(1);
      end else begin
         mag = ipart[DRIVE_BITS-1:0];
      end
   end

endmodule

// ===== rtl/core/tcpd_merge.sv =====
// ----------------------------------------------------------------------------
// tcpd_merge
// Pipeline valid tracking and flow control, and the output register that
// joins both lane drives with the done flag and reverse sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpd_merge
   import tcpd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         done,
   input  logic                         reverse,
   input  logic        [DRIVE_BITS-1:0] left_mag,
   input  logic        [DRIVE_BITS-1:0] right_mag,
   output pipe_ctl_type                 ctl,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DRIVE_BITS-1:0] rsp_left_drive,
   output logic signed [DRIVE_BITS-1:0] rsp_right_drive,
   output logic                         rsp_done_res
);

   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic dn1_ff, dn2_ff, dn3_ff;
   logic rv1_ff, rv2_ff, rv3_ff;
   logic signed [DRIVE_BITS-1:0] left_ff, right_ff;
   logic done_ff;
   logic out_en;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      out_en     = !out_v_ff || !rsp_stall;
      ctl.s3_en  = !s3_v_ff || out_en;
      ctl.s2_en  = !s2_v_ff || ctl.s3_en;
      ctl.s1_en  = !s1_v_ff || ctl.s2_en;
      req_stall  = !ctl.s1_en;
      ctl.accept = req_valid && ctl.s1_en;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (ctl.s1_en) s1_v_ff  <= ctl.accept;
         if (ctl.s2_en) s2_v_ff  <= s1_v_ff;
         if (ctl.s3_en) s3_v_ff  <= s2_v_ff;
         if (out_en)    out_v_ff <= s3_v_ff;
      end
   end

   // done and sign travel alongside the lanes; merged into the result item
   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         dn1_ff <= done;
         rv1_ff <= reverse;
      end
      if (ctl.s2_en) begin
         dn2_ff <= dn1_ff;
         rv2_ff <= rv1_ff;
      end
      if (ctl.s3_en) begin
         dn3_ff <= dn2_ff;
         rv3_ff <= rv2_ff;
      end
      if (out_en) begin
         done_ff <= dn3_ff;
         if (dn3_ff) begin
            left_ff  <= '0;
            right_ff <= '0;
         end else if (rv3_ff) begin
            left_ff  <= $signed(DRIVE_BITS'(0) - left_mag);
            right_ff <= $signed(DRIVE_BITS'(0) - right_mag);
         end else begin
            left_ff  <= $signed(left_mag);
            right_ff <= $signed(right_mag);
         end
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_done_res    = done_ff;

endmodule

// ===== rtl/core/two_channel_pid_drive_core.sv =====
// ----------------------------------------------------------------------------
// two_channel_pid_drive_core
// Dual-side PID position controller. Each item is one control tick carrying
// the left and right encoder positions; each result item gives both drive
// percentages and a done flag. The core takes one item per clock cycle while
// req_stall is low. The integral and last error of each side are updated
// as an item is accepted; the item then passes a register of error,
// integral and difference, one stage of per-side gain multipliers, one
// partial-sum stage and the final sum with clamping feeding the output
// register. The output register lets a new item in while a result waits;
// req_stall rises only when all pipeline stages hold items behind a
// stalled result. Gains and target are written through the csr port, which
// is always ready and must only be used while no items are in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_channel_pid_drive_core
   import tcpd_pkg::*;
#(
   parameter int POSITION_BITS  = POSITION_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
   parameter int MAX_DRIVE      = MAX_DRIVE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_start_move,
   input  logic signed [POSITION_BITS-1:0] req_left_position,
   input  logic signed [POSITION_BITS-1:0] req_right_position,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [DRIVE_BITS-1:0]    rsp_left_drive,
   output logic signed [DRIVE_BITS-1:0]    rsp_right_drive,
   output logic                            rsp_done_res,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic        [CSR_IDX_BITS-1:0]  csr_index,
   input  logic        [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CW = (POSITION_BITS > TARGET_BITS) ? POSITION_BITS : TARGET_BITS;

   logic signed [TARGET_BITS-1:0] target_ff;
   logic [GAIN_BITS-1:0] left_kp_ff, left_ki_ff, left_kd_ff;
   logic [GAIN_BITS-1:0] right_kp_ff, right_ki_ff, right_kd_ff;

   logic [TARGET_BITS-1:0]   tabs;
   logic [POSITION_BITS-1:0] lpos_abs;
   logic                     done;
   logic [DRIVE_BITS-1:0]    left_mag, right_mag;
   pipe_ctl_type             ctl;

   assign csr_ready = 1'b1;

   // register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         left_kp_ff  <= LEFT_KP_RST;
         left_ki_ff  <= LEFT_KI_RST;
         left_kd_ff  <= LEFT_KD_RST;
         right_kp_ff <= RIGHT_KP_RST;
         right_ki_ff <= RIGHT_KI_RST;
         right_kd_ff <= RIGHT_KD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET:   target_ff   <= $signed(csr_wdata[TARGET_BITS-1:0]);
            CSR_LEFT_KP:  left_kp_ff  <= csr_wdata[GAIN_BITS-1:0];
            CSR_LEFT_KI:  left_ki_ff  <= csr_wdata[GAIN_BITS-1:0];
            CSR_LEFT_KD:  left_kd_ff  <= csr_wdata[GAIN_BITS-1:0];
            CSR_RIGHT_KP: right_kp_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_RIGHT_KI: right_ki_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_RIGHT_KD: right_kd_ff <= csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // target magnitude and done test on the left side
   always_comb begin
      tabs     = target_ff[TARGET_BITS-1] ? TARGET_BITS'(-target_ff)
                                          : TARGET_BITS'(target_ff);
      lpos_abs = req_left_position[POSITION_BITS-1] ? POSITION_BITS'(-req_left_position)
                                                    : POSITION_BITS'(req_left_position);
      done     = CW'(lpos_abs) > CW'(tabs);
   end

   tcpd_lane #(
      .POSITION_BITS  (POSITION_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .MAX_DRIVE      (MAX_DRIVE)
   ) u_left_lane (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .start_move (req_start_move),
      .done       (done),
      .tabs       (tabs),
      .position   (req_left_position),
      .kp         (left_kp_ff),
      .ki         (left_ki_ff),
      .kd         (left_kd_ff),
      .mag        (left_mag)
   );

   tcpd_lane #(
      .POSITION_BITS  (POSITION_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .MAX_DRIVE      (MAX_DRIVE)
   ) u_right_lane (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .start_move (req_start_move),
      .done       (done),
      .tabs       (tabs),
      .position   (req_right_position),
      .kp         (right_kp_ff),
      .ki         (right_ki_ff),
      .kd         (right_kd_ff),
      .mag        (right_mag)
   );

   tcpd_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .done            (done),
      .reverse         (target_ff[TARGET_BITS-1]),
      .left_mag        (left_mag),
      .right_mag       (right_mag),
      .ctl             (ctl),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_done_res    (rsp_done_res)
   );

endmodule

// ===== rtl/core/tcpd_checker.sv =====
// ----------------------------------------------------------------------------
// tcpd_checker
// Port-level checks on the two-channel PID drive core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpd_checker
   import tcpd_pkg::*;
#(
   parameter int MAX_DRIVE     = MAX_DRIVE_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [DRIVE_BITS-1:0]    rsp_left_drive,
   input logic signed [DRIVE_BITS-1:0]    rsp_right_drive,
   input logic                            rsp_done_res
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_done_res)))
      else $error("result item changed while stalled");

   // input stalls only when the pipeline is backed up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with no stalled result");

   // done ticks carry zero drive
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_left_drive == 0 && rsp_right_drive == 0))
      else $error("non-zero drive on a done item");

   // otherwise each drive is between 1 and MAX_DRIVE in magnitude
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |->
         (rsp_left_drive != 0 && rsp_left_drive <= MAX_DRIVE
          && rsp_left_drive >= -MAX_DRIVE
          && rsp_right_drive != 0 && rsp_right_drive <= MAX_DRIVE
          && rsp_right_drive >= -MAX_DRIVE))
      else $error("drive out of range");

endmodule

bind two_channel_pid_drive_core tcpd_checker #(
   .MAX_DRIVE     (MAX_DRIVE)
) u_tcpd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_left_drive     (rsp_left_drive),
   .rsp_right_drive    (rsp_right_drive),
   .rsp_done_res       (rsp_done_res)
);
